// ----- hdl/bpd_pkg.sv -----
package bpd_pkg;

	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int COORD_W  = 24;
	localparam int RAD_W    = 12;
	localparam int FACTOR_W = 12;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int D2_W     = SQ_W + 2;
	localparam int RSUM_W   = RAD_W + 1;
	localparam int T_W      = RSUM_W + FACTOR_W;
	localparam int TT_W     = 2 * T_W;
	localparam int D2_CUT   = 34;
	localparam int FRAC_SH  = 16;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd333;

	// input word: one atom
	typedef struct packed {
		logic                      new_frame;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [RAD_W-1:0]          atom_radius;
	} bpd_in_t;

	// output word: one result
	typedef struct packed {
		logic [IDX_W-1:0] earlier_atom;
		logic [IDX_W-1:0] current_atom;
		logic             found;
		logic             overflow;
		logic             last;
	} bpd_out_t;

	// one stored atom
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [RAD_W-1:0]          r;
	} bpd_atom_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;    // latch input atom, store it unless ovf
		logic             ovf;     // frame full, atom dropped
		logic             issue;   // read stored atom idx into the pipe
		logic             finish;  // emit the closing result
		logic [IDX_W-1:0] idx;     // store / current / read index
	} bpd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic adv;       // pipe moves this cycle
		logic busy;      // any compare still in flight
		logic out_free;  // output register can take a word
	} bpd_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} bpd_state_t;

endpackage

// ----- hdl/bond_pair_detector.sv -----
// An atom stored as index n is tested against stored atoms 0 to n-1; the
//   pipe drains, its last word goes out once the output is free (empty or
//   full frame: no tests), and only then is a new atom accepted. The single
//   store read port feeds a 4-stage pipe one test per cycle unless stalled.
// Reset: arst_n clears control, the frame count and bond_factor (333);
//   the atom store is not cleared.
module bond_pair_detector
	import bpd_pkg::*;
#(
	parameter int MAX_ATOMS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpd_in_t             in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bpd_out_t            out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [FACTOR_W-1:0] cfg_data
);

	bpd_cmd_t  cmd;
	bpd_stat_t stat;

	assign cfg_ready = 1'b1;

	bpd_ctrl #(
		.MAX_ATOMS(MAX_ATOMS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_new_frame(in_data.new_frame),
		.in_ready    (in_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	bpd_dp #(
		.MAX_ATOMS(MAX_ATOMS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ----- hdl/bpd_ctrl.sv -----
module bpd_ctrl
	import bpd_pkg::*;
#(
	parameter int MAX_ATOMS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_new_frame,
	output logic      in_ready,
	input  bpd_stat_t stat,
	output bpd_cmd_t  cmd
);

	bpd_state_t       state_q, state_nx;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] k_q;
	logic [CNT_W-1:0] base;
	logic             full;
	logic             accept;
	logic             scan_end;

	// slot for an arriving atom
	assign base     = in_new_frame ? '0 : count_q;
	assign full     = (base >= CNT_W'(MAX_ATOMS));
	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign scan_end = (k_q == cur_q - IDX_W'(1));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (full || base == '0)
						state_nx = ST_FINISH;
					else
						state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.adv && scan_end)
					state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.busy)
					state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.ovf    = full;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		cmd.idx    = base[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.idx  = full ? '0 : base[IDX_W-1:0];
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				cmd.idx   = k_q;
			end
			ST_DRAIN: begin
				cmd.idx = k_q;
			end
			ST_FINISH: begin
				cmd.finish = stat.out_free;
				cmd.idx    = cur_q;
			end
			default: begin
				cmd.idx = k_q;
			end
		endcase
	end

	// state, frame count, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cur_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				k_q <= '0;
				if (!full) begin
					count_q <= base + CNT_W'(1);
					cur_q   <= base[IDX_W-1:0];
				end
			end else if (state_q == ST_SCAN && stat.adv && !scan_end) begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

endmodule

// ----- hdl/bpd_dp.sv -----
module bpd_dp
	import bpd_pkg::*;
#(
	parameter int MAX_ATOMS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpd_in_t             in_data,
	input  logic                cfg_valid,
	input  logic [FACTOR_W-1:0] cfg_data,
	input  bpd_cmd_t            cmd,
	output bpd_stat_t           stat,
	output logic                out_valid,
	input  logic                out_ready,
	output bpd_out_t            out_data
);

	localparam int ADDR_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

	bpd_atom_t           atom_mem_q [MAX_ATOMS];
	logic [FACTOR_W-1:0] factor_q;

	// new atom and its frame slot
	bpd_atom_t           new_q;
	logic [IDX_W-1:0]    cur_q;
	logic                ovf_q;

	// compare pipe
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]    k_s1, k_s2, k_s3, k_s4;
	bpd_atom_t           rd_s1;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [RSUM_W-1:0]   rsum_s2;
	logic [SQ_W-1:0]     sx_s3, sy_s3, sz_s3;
	logic [T_W-1:0]      t_s3;
	logic [D2_W-1:0]     d2_s4;
	logic [TT_W-1:0]     tt_s4;

	logic signed [2*DIFF_W-1:0] px, py, pz;
	logic [TT_W-1:0]     d2_sh;
	logic                hit;
	logic                tail_hit;
	logic                push_pend;
	logic                out_free;
	logic                adv;

	// closing result and pending pair
	logic                pend_v_q;
	logic [IDX_W-1:0]    pend_k_q;
	logic                out_v_q;
	bpd_out_t            out_q;

	assign out_free  = !out_v_q || out_ready;
	assign d2_sh     = {d2_s4[D2_CUT-1:0], FRAC_SH'(0)};
	assign hit       = (d2_s4 < D2_W'(64'd1 << D2_CUT)) && (d2_sh < tt_s4);
	assign tail_hit  = v_s4 && hit;
	assign push_pend = tail_hit && pend_v_q;
	assign adv       = !push_pend || out_free;

	assign stat.adv      = adv;
	assign stat.busy     = v_s1 || v_s2 || v_s3 || v_s4;
	assign stat.out_free = out_free;

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			factor_q <= FACTOR_RESET;
		else if (cfg_valid)
			factor_q <= cfg_data;
	end

	// atom store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.load && !cmd.ovf)
			atom_mem_q[cmd.idx[ADDR_W-1:0]] <= '{x: in_data.pos_x, y: in_data.pos_y,
				z: in_data.pos_z, r: in_data.atom_radius};
		if (adv && cmd.issue)
			rd_s1 <= atom_mem_q[cmd.idx[ADDR_W-1:0]];
	end

	// latch arriving atom
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q <= '{x: in_data.pos_x, y: in_data.pos_y,
				z: in_data.pos_z, r: in_data.atom_radius};
			cur_q <= cmd.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovf_q <= 1'b0;
		else if (cmd.load)
			ovf_q <= cmd.ovf;
	end

	// pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;
	assign pz = dz_s2 * dz_s2;

	// stage 2 differences, stage 3 squares, stage 4 sums
	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd.issue)
				k_s1 <= cmd.idx;
			k_s2    <= k_s1;
			dx_s2   <= DIFF_W'(new_q.x) - DIFF_W'(rd_s1.x);
			dy_s2   <= DIFF_W'(new_q.y) - DIFF_W'(rd_s1.y);
			dz_s2   <= DIFF_W'(new_q.z) - DIFF_W'(rd_s1.z);
			rsum_s2 <= RSUM_W'(new_q.r) + RSUM_W'(rd_s1.r);
			k_s3    <= k_s2;
			sx_s3   <= px[SQ_W-1:0];
			sy_s3   <= py[SQ_W-1:0];
			sz_s3   <= pz[SQ_W-1:0];
			t_s3    <= T_W'(rsum_s2) * T_W'(factor_q);
			k_s4    <= k_s3;
			d2_s4   <= D2_W'(sx_s3) + D2_W'(sy_s3) + D2_W'(sz_s3);
			tt_s4   <= TT_W'(t_s3) * TT_W'(t_s3);
		end
	end

	// pending pair: held back until the next pair or the scan end shows last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.finish) begin
			pend_v_q <= 1'b0;
		end else if (adv && tail_hit) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail_hit)
			pend_k_q <= k_s4;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if ((push_pend && out_free) || cmd.finish)
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		priority if (push_pend && out_free) begin
			out_q <= '{earlier_atom: pend_k_q, current_atom: cur_q,
				found: 1'b1, overflow: 1'b0, last: 1'b0};
		end else if (cmd.finish) begin
			priority if (ovf_q)
				out_q <= '{earlier_atom: '0, current_atom: '0,
					found: 1'b0, overflow: 1'b1, last: 1'b1};
			else if (pend_v_q)
				out_q <= '{earlier_atom: pend_k_q, current_atom: cur_q,
					found: 1'b1, overflow: 1'b0, last: 1'b1};
			else
				out_q <= '{earlier_atom: '0, current_atom: cur_q,
					found: 1'b0, overflow: 1'b0, last: 1'b1};
		end else begin
			out_q <= out_q;
		end
	end

endmodule

// ----- hdl/bpd_checker.sv -----
module bpd_checker
	import bpd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input bpd_out_t out_data
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// one atom at a time: input closes right after an accept
	a_one_atom: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input open again right after accept");

	// while open for input, only a closing word can wait at the output
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_ready |-> out_data.last)
		else $error("non-final word pending while idle");

	// no new word can appear while input is open
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && $past(in_ready) && $past(!out_valid) |-> !out_valid)
		else $error("word emitted while idle");

endmodule

bind bond_pair_detector bpd_checker u_bpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
